// ----- rtl/core/matrix_stack_engine_assert.svh -----
// Assertion macros for the matrix stack engine checker.
// Used by mse_checker; needs a clock named clk and reset named arst_n in scope.
`ifndef MATRIX_STACK_ENGINE_ASSERT_SVH
`define MATRIX_STACK_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mse_pkg.sv -----
// Shared types, constants and float helpers for the matrix stack engine.
// No dependencies; imported by every module of the block except mse_ram.
`timescale 1ns / 1ps
package mse_pkg;

	localparam int MV_LEVELS = 32;
	localparam int PJ_LEVELS = 4;
	localparam int MAT_WORDS = (MV_LEVELS + PJ_LEVELS) * 16;
	localparam int MAT_AW    = $clog2(MAT_WORDS);
	localparam int MV_LW     = $clog2(MV_LEVELS);
	localparam int PJ_LW     = $clog2(PJ_LEVELS);
	localparam int PJ_BASE   = MV_LEVELS * 16;

	localparam int S_DW = 40;
	localparam int S_UW = 4;
	localparam int M_DW = 40;
	localparam int M_UW = 2;

	localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
	localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;
	localparam logic [31:0] FP_QBIT = 32'h0040_0000;

	typedef enum logic [2:0] {
		OP_IDENT  = 3'd0,
		OP_PUSH   = 3'd1,
		OP_POP    = 3'd2,
		OP_LOAD   = 3'd3,
		OP_LOAD_T = 3'd4,
		OP_MUL    = 3'd5,
		OP_MUL_T  = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_INVALID   = 2'd1,
		STAT_OVERFLOW  = 2'd2,
		STAT_UNDERFLOW = 2'd3
	} status_t;

	// leading zero count of a 48-bit word (48 when zero)
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// round to nearest even and pack; ef is the biased exponent minus one
	// (zero for subnormals), mant carries the hidden bit at bit 23
	function automatic logic [31:0] fp_round_pack(input logic sgn, input logic [9:0] ef,
			input logic [23:0] mant, input logic g, input logic st);
		logic up;
		logic [32:0] sum;
		up  = g & (st | mant[0]);
		sum = {ef, 23'b0} + 33'(mant) + 33'(up);
		if (sum[32:23] >= 10'd255) return {sgn, 8'hFF, 23'b0};
		return {sgn, sum[30:0]};
	endfunction

endpackage

// ----- rtl/core/matrix_stack_engine.sv -----
// Matrix stack engine: two 4x4 float matrix stacks held in one RAM.
// Pop and rejected commands go straight to the response; element beats are taken while
// idle; identity writes the top matrix word by word, push and load copy a matrix word by word;
// read top reads one word per output beat; multiply walks every one of the 64 products
// in turn through the single multiplier and adder pair (4 + 4 stages).
// One command at a time. Reset clears levels, mode register and control; RAM is undefined.
`timescale 1ns / 1ps
module matrix_stack_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic                     cfg_wdata,  // immediate_active
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [mse_pkg::S_DW-1:0] s_tdata,   // element_index[3:0], element_value[35:4]
	input  logic [mse_pkg::S_UW-1:0] s_tuser,   // operation[2:0], stack_select[3]
	input  logic                     s_tlast,   // last_element
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [mse_pkg::M_DW-1:0] m_tdata,   // read_index[3:0], read_value[35:4]
	output logic [mse_pkg::M_UW-1:0] m_tuser,   // status[1:0]
	output logic                     m_tlast    // last_of_run
);
	import mse_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_IDENT = 10'b00_0000_0010,
		S_COPY  = 10'b00_0000_0100,
		S_MRD   = 10'b00_0000_1000,
		S_MMUL  = 10'b00_0001_0000,
		S_MWAIT = 10'b00_0010_0000,
		S_AWAIT = 10'b00_0100_0000,
		S_MWB   = 10'b00_1000_0000,
		S_RDT   = 10'b01_0000_0000,
		S_RESP  = 10'b10_0000_0000
	} state_t;

	state_t         state_q;
	op_t            op_q, in_op;
	status_t        status_q, out_status_q;
	logic           sel_q, imm_q, in_sel, accept, is_stream;
	logic [4:0]     cnt_q;
	logic [1:0]     row_q, col_q, k_q;
	logic [31:0]    acc_q;
	logic [31:0]    rowbuf_q [4];
	logic [MV_LW-1:0] mv_lvl_q;
	logic [PJ_LW-1:0] pj_lvl_q;
	logic           wr_v_s1, rd_pend_s1;
	logic [3:0]     wr_i_s1, rd_i_s1;
	logic           out_valid_q, out_last_q, out_free, out_load;
	logic [3:0]     out_idx_q;
	logic [31:0]    out_val_q;

	logic              mat_we, ob_we;
	logic [MAT_AW-1:0] mat_waddr, mat_raddr, top;
	logic [31:0]       mat_wdata, mat_rdata, ob_rdata;
	logic [3:0]        ob_raddr;
	logic              mul_go, mul_ov, add_go, add_ov;
	logic [31:0]       mul_y, add_y;

	assign in_op     = op_t'(s_tuser[2:0]);
	assign in_sel    = s_tuser[3];
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_stream = (in_op == OP_LOAD) || (in_op == OP_LOAD_T) ||
		(in_op == OP_MUL) || (in_op == OP_MUL_T);
	assign ob_we     = accept && is_stream;
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = ((state_q == S_RDT) && rd_pend_s1) || ((state_q == S_RESP) && out_free);

	// base address of the selected top matrix
	assign top = sel_q ? MAT_AW'(PJ_BASE) + MAT_AW'({pj_lvl_q, 4'b0000})
		: MAT_AW'({mv_lvl_q, 4'b0000});

	mse_ram #(.WIDTH(32), .DEPTH(MAT_WORDS)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	mse_ram #(.WIDTH(32), .DEPTH(16)) u_op_ram (
		.clk   (clk),
		.we    (ob_we),
		.waddr (s_tdata[3:0]),
		.wdata (s_tdata[35:4]),
		.raddr (ob_raddr),
		.rdata (ob_rdata)
	);

	mse_fmul u_fmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_go),
		.a         (mat_rdata),
		.b         (ob_rdata),
		.out_valid (mul_ov),
		.y         (mul_y)
	);

	mse_fadd u_fadd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (add_go),
		.a         (acc_q),
		.b         (mul_y),
		.out_valid (add_ov),
		.y         (add_y)
	);

	assign mul_go = (state_q == S_MMUL);
	assign add_go = (state_q == S_MWAIT) && mul_ov && (k_q != 2'd0);

	// RAM address and write steering
	always_comb begin
		mat_we    = 1'b0;
		mat_waddr = top;
		mat_wdata = 32'b0;
		mat_raddr = top + MAT_AW'(cnt_q[3:0]);
		ob_raddr  = cnt_q[3:0];
		if (wr_v_s1) begin
			mat_we    = 1'b1;
			mat_waddr = top + ((op_q == OP_PUSH) ? MAT_AW'(16) : MAT_AW'(0)) + MAT_AW'(wr_i_s1);
			mat_wdata = (op_q == OP_PUSH) ? mat_rdata : ob_rdata;
		end
		unique case (state_q)
			S_IDENT: begin
				mat_we    = 1'b1;
				mat_waddr = top + MAT_AW'(cnt_q[3:0]);
				case (cnt_q[3:0]) inside
					4'd0, 4'd5, 4'd10, 4'd15: mat_wdata = FP_ONE;
					default:                  mat_wdata = 32'b0;
				endcase
			end
			S_COPY: begin
				if (op_q == OP_LOAD_T) ob_raddr = {cnt_q[1:0], cnt_q[3:2]};
			end
			S_MRD: begin
				mat_raddr = top + MAT_AW'({k_q, row_q});
				ob_raddr  = (op_q == OP_MUL_T) ? {k_q, col_q} : {col_q, k_q};
			end
			S_MWB: begin
				mat_we    = 1'b1;
				mat_waddr = top + MAT_AW'({cnt_q[1:0], row_q});
				mat_wdata = rowbuf_q[cnt_q[1:0]];
			end
			S_IDLE, S_MMUL, S_MWAIT, S_AWAIT, S_RDT, S_RESP: ;
			default: ;
		endcase
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_IDENT;
			sel_q       <= 1'b0;
			status_q    <= STAT_OK;
			imm_q       <= 1'b0;
			cnt_q       <= 5'd0;
			row_q       <= 2'd0;
			col_q       <= 2'd0;
			k_q         <= 2'd0;
			mv_lvl_q    <= '0;
			pj_lvl_q    <= '0;
			wr_v_s1     <= 1'b0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) imm_q <= cfg_wdata;
			wr_v_s1 <= (state_q == S_COPY) && !cnt_q[4];
			// output register: loaded by a new beat, emptied by the sink
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (!is_stream || s_tlast)) begin
						op_q     <= in_op;
						sel_q    <= in_sel;
						cnt_q    <= 5'd0;
						row_q    <= 2'd0;
						col_q    <= 2'd0;
						k_q      <= 2'd0;
						status_q <= STAT_OK;
						if (imm_q) begin
							status_q <= STAT_INVALID;
							state_q  <= S_RESP;
						end else begin
							unique case (in_op)
								OP_IDENT: state_q <= S_IDENT;
								OP_PUSH: begin
									if (in_sel ? (pj_lvl_q == PJ_LW'(PJ_LEVELS - 1))
											: (mv_lvl_q == MV_LW'(MV_LEVELS - 1))) begin
										status_q <= STAT_OVERFLOW;
										state_q  <= S_RESP;
									end else begin
										state_q <= S_COPY;
									end
								end
								OP_POP: begin
									state_q <= S_RESP;
									if (in_sel ? (pj_lvl_q == '0) : (mv_lvl_q == '0))
										status_q <= STAT_UNDERFLOW;
									else if (in_sel) pj_lvl_q <= pj_lvl_q - PJ_LW'(1);
									else mv_lvl_q <= mv_lvl_q - MV_LW'(1);
								end
								OP_LOAD, OP_LOAD_T: state_q <= S_COPY;
								OP_MUL, OP_MUL_T:   state_q <= S_MRD;
								OP_READ:            state_q <= S_RDT;
								default:            state_q <= S_RESP;
							endcase
						end
					end
				end
				S_IDENT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[3:0] == 4'd15) state_q <= S_RESP;
				end
				S_COPY: begin
					// read one word a cycle, write it back in the following cycle
					if (!cnt_q[4]) begin
						cnt_q   <= cnt_q + 5'd1;
						wr_i_s1 <= cnt_q[3:0];
					end else begin
						state_q <= S_RESP;
						if (op_q == OP_PUSH) begin
							if (sel_q) pj_lvl_q <= pj_lvl_q + PJ_LW'(1);
							else mv_lvl_q <= mv_lvl_q + MV_LW'(1);
						end
					end
				end
				S_MRD:  state_q <= S_MMUL;
				S_MMUL: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_ov) begin
						if (k_q == 2'd0) begin
							acc_q   <= mul_y;
							k_q     <= 2'd1;
							state_q <= S_MRD;
						end else begin
							state_q <= S_AWAIT;
						end
					end
				end
				S_AWAIT: begin
					// accumulate; a finished element goes to the row buffer
					if (add_ov) begin
						acc_q <= add_y;
						if (k_q != 2'd3) begin
							k_q     <= k_q + 2'd1;
							state_q <= S_MRD;
						end else begin
							rowbuf_q[col_q] <= add_y;
							k_q <= 2'd0;
							if (col_q != 2'd3) begin
								col_q   <= col_q + 2'd1;
								state_q <= S_MRD;
							end else begin
								col_q   <= 2'd0;
								cnt_q   <= 5'd0;
								state_q <= S_MWB;
							end
						end
					end
				end
				S_MWB: begin
					// row results written only after the whole row was read
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd3) begin
						if (row_q == 2'd3) begin
							state_q <= S_RESP;
						end else begin
							row_q   <= row_q + 2'd1;
							state_q <= S_MRD;
						end
					end
				end
				S_RDT: begin
					if (rd_pend_s1) begin
						rd_pend_s1   <= 1'b0;
						out_status_q <= STAT_OK;
						out_idx_q    <= rd_i_s1;
						out_val_q    <= mat_rdata;
						out_last_q   <= (rd_i_s1 == 4'd15);
						if (rd_i_s1 == 4'd15) state_q <= S_IDLE;
					end else if (out_free && !cnt_q[4]) begin
						rd_pend_s1 <= 1'b1;
						rd_i_s1    <= cnt_q[3:0];
						cnt_q      <= cnt_q + 5'd1;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_idx_q    <= 4'd0;
						out_val_q    <= 32'b0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_val_q, out_idx_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- rtl/core/mse_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/mse_fmul.sv -----
// Single-precision multiplier, four pipeline stages, round to nearest even.
// Depends on mse_pkg for rounding and leading zero helpers.
`timescale 1ns / 1ps
module mse_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] y
);
	import mse_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               sgn_s1, sgn_s2, sgn_s3;
	logic               spec_s1, spec_s2, spec_s3;
	logic [31:0]        spy_s1, spy_s2, spy_s3, y_s4;
	logic [47:0]        prod_s1, prod_s2, n_s3;
	logic signed [10:0] e0_s1;
	logic               left_s2, st_s3;
	logic [6:0]         sh_s2;
	logic [9:0]         ef_s2, ef_s3;

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn, spec;
	logic [31:0] spy;
	logic [23:0] ma, mb;
	logic [7:0]  eae, ebe;

	// stage 1: unpack, specials, mantissa product
	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
		a_zero = (a[30:0] == 31'b0);
		b_zero = (b[30:0] == 31'b0);
		sgn    = a[31] ^ b[31];
		ma     = {a[30:23] != 8'h00, a[22:0]};
		mb     = {b[30:23] != 8'h00, b[22:0]};
		eae    = (a[30:23] == 8'h00) ? 8'd1 : a[30:23];
		ebe    = (b[30:23] == 8'h00) ? 8'd1 : b[30:23];
		spec   = 1'b1;
		spy    = 32'b0;
		if (a_nan) spy = a | FP_QBIT;
		else if (b_nan) spy = b | FP_QBIT;
		else if ((a_inf && b_zero) || (b_inf && a_zero)) spy = FP_QNAN;
		else if (a_inf || b_inf) spy = {sgn, 8'hFF, 23'b0};
		else if (a_zero || b_zero) spy = {sgn, 31'b0};
		else spec = 1'b0;
	end

	logic [5:0]         lz;
	logic signed [10:0] el;

	// stage 2 planning: leading zeros and shift direction
	always_comb begin
		lz = lzc48(prod_s1);
		el = e0_s1 - $signed({5'b0, lz});
	end

	logic [47:0] mask;
	assign mask = ~(48'hFFFF_FFFF_FFFF << sh_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		sgn_s1  <= sgn;
		spec_s1 <= spec;
		spy_s1  <= spy;
		prod_s1 <= ma * mb;
		e0_s1   <= $signed({3'b0, eae}) + $signed({3'b0, ebe}) - 11'sd126;
		// stage 2
		sgn_s2  <= sgn_s1;
		spec_s2 <= spec_s1;
		spy_s2  <= spy_s1;
		prod_s2 <= prod_s1;
		if (el >= 11'sd1) begin
			left_s2 <= 1'b1;
			sh_s2   <= 7'(lz);
			ef_s2   <= 10'(el - 11'sd1);
		end else if (e0_s1 >= 11'sd1) begin
			left_s2 <= 1'b1;
			sh_s2   <= 7'(e0_s1 - 11'sd1);
			ef_s2   <= 10'd0;
		end else begin
			left_s2 <= 1'b0;
			sh_s2   <= (e0_s1 < -11'sd62) ? 7'd63 : 7'(11'sd1 - e0_s1);
			ef_s2   <= 10'd0;
		end
		// stage 3: shift with sticky on right shifts
		sgn_s3  <= sgn_s2;
		spec_s3 <= spec_s2;
		spy_s3  <= spy_s2;
		ef_s3   <= ef_s2;
		n_s3    <= left_s2 ? (prod_s2 << sh_s2) : (prod_s2 >> sh_s2);
		st_s3   <= left_s2 ? 1'b0 : |(prod_s2 & mask);
		// stage 4: round and pack
		y_s4 <= spec_s3 ? spy_s3 :
			fp_round_pack(sgn_s3, ef_s3, n_s3[47:24], n_s3[23], (|n_s3[22:0]) | st_s3);
	end

	assign out_valid = v_s4;
	assign y         = y_s4;

endmodule

// ----- rtl/core/mse_fadd.sv -----
// Single-precision adder, four pipeline stages, round to nearest even.
// Depends on mse_pkg for rounding and leading zero helpers.
`timescale 1ns / 1ps
module mse_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] y
);
	import mse_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        sgn_s1, sgn_s2, sgn_s3;
	logic        spec_s1, spec_s2, spec_s3;
	logic        zero_s2, zero_s3;
	logic [31:0] spy_s1, spy_s2, spy_s3, y_s4;
	logic [27:0] z_s1, z_s2, n_s3;
	logic [7:0]  ex_s1;
	logic [4:0]  sh_s2;
	logic [9:0]  ef_s2, ef_s3;

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, spec;
	logic [31:0] spy, x, w;
	logic [7:0]  exe, eye, d;
	logic [26:0] mx, my, al;
	logic [27:0] z;

	// stage 1: specials, order by magnitude, align, add
	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
		a_zero = (a[30:0] == 31'b0);
		b_zero = (b[30:0] == 31'b0);
		spec   = 1'b1;
		spy    = 32'b0;
		if (a_nan) spy = a | FP_QBIT;
		else if (b_nan) spy = b | FP_QBIT;
		else if (a_inf && b_inf && (a[31] != b[31])) spy = FP_QNAN;
		else if (a_inf) spy = a;
		else if (b_inf) spy = b;
		else if (a_zero && b_zero) spy = {a[31] & b[31], 31'b0};
		else if (a_zero) spy = b;
		else if (b_zero) spy = a;
		else spec = 1'b0;
		x   = (a[30:0] >= b[30:0]) ? a : b;
		w   = (a[30:0] >= b[30:0]) ? b : a;
		exe = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
		eye = (w[30:23] == 8'h00) ? 8'd1 : w[30:23];
		d   = exe - eye;
		mx  = {x[30:23] != 8'h00, x[22:0], 3'b000};
		my  = {w[30:23] != 8'h00, w[22:0], 3'b000};
		if (d >= 8'd27) al = {26'b0, my != 27'b0};
		else al = (my >> d) | {26'b0, |(my & ~(27'h7FF_FFFF << d))};
		z = (x[31] ^ w[31]) ? ({1'b0, mx} - {1'b0, al}) : ({1'b0, mx} + {1'b0, al});
	end

	logic [5:0]         lz;
	logic signed [9:0]  el;

	// stage 2 planning: leading zeros of the sum
	always_comb begin
		lz = lzc48({z_s1, 20'b0});
		el = $signed({2'b0, ex_s1}) + 10'sd1 - $signed({4'b0, lz});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		sgn_s1  <= x[31];
		spec_s1 <= spec;
		spy_s1  <= spy;
		z_s1    <= z;
		ex_s1   <= exe;
		// stage 2
		sgn_s2  <= sgn_s1;
		spec_s2 <= spec_s1;
		spy_s2  <= spy_s1;
		z_s2    <= z_s1;
		zero_s2 <= (z_s1 == 28'b0);
		if (el >= 10'sd1) begin
			sh_s2 <= 5'(lz);
			ef_s2 <= 10'(el - 10'sd1);
		end else begin
			sh_s2 <= 5'(ex_s1);
			ef_s2 <= 10'd0;
		end
		// stage 3: normalize
		sgn_s3  <= sgn_s2;
		spec_s3 <= spec_s2;
		spy_s3  <= spy_s2;
		zero_s3 <= zero_s2;
		ef_s3   <= ef_s2;
		n_s3    <= z_s2 << sh_s2;
		// stage 4: round and pack; exact cancellation gives +0
		if (spec_s3) y_s4 <= spy_s3;
		else if (zero_s3) y_s4 <= 32'b0;
		else y_s4 <= fp_round_pack(sgn_s3, ef_s3, n_s3[27:4], n_s3[3], |n_s3[2:0]);
	end

	assign out_valid = v_s4;
	assign y         = y_s4;

endmodule

// ----- rtl/core/mse_checker.sv -----
// Port-level checker for the matrix stack engine result stream, bound to the top.
// Depends on mse_pkg and matrix_stack_engine_assert.svh.
`timescale 1ns / 1ps
`include "matrix_stack_engine_assert.svh"
module mse_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [mse_pkg::M_DW-1:0] m_tdata,
	input logic [mse_pkg::M_UW-1:0] m_tuser,
	input logic                     m_tlast
);
	import mse_pkg::*;

	// a stalled beat holds
	`MSE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")
	// error results are single, empty beats
	`MSE_ASSERT_NOW(a_err_beat, m_tvalid && (m_tuser != STAT_OK), m_tlast && (m_tdata == '0), "error beat carries data or is not last")
	// only read-top runs span several beats, and they are always ok
	`MSE_ASSERT_NOW(a_run_ok, m_tvalid && !m_tlast, m_tuser == STAT_OK, "non-final beat with error status")
	// a final beat with an index must be the sixteenth element
	`MSE_ASSERT_NOW(a_last_idx, m_tvalid && m_tlast && (m_tdata[3:0] != 4'd0), m_tdata[3:0] == 4'd15, "read run ended early")

endmodule

bind matrix_stack_engine mse_checker u_mse_checker (.*);

// ----- tb/matrix_stack_engine_test.sv -----
// Self-checking testbench for matrix_stack_engine: streams stack commands, predicts every
// result beat with a bit-exact float model of its own and compares at the output stream.
// Depends on mse_pkg and the matrix_stack_engine RTL only.
`timescale 1ns / 1ps
module matrix_stack_engine_test;
	import mse_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		status_t   st;
		bit [3:0]  ri;
		bit [31:0] rv;
		bit        rl;
	} result_beat_t;

	// float helpers: products and sums are formed in double, then rounded once to single
	function automatic real single_to_real(bit [31:0] b);
		if (b[30:0] == 0) return $bitstoreal({b[31], 63'b0});
		return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'b0});
	endfunction

	function automatic bit [31:0] real_to_single(real r);
		bit [63:0] d;
		longint unsigned m, kept;
		int e, eb, sh;
		bit g, stk, up;
		bit [33:0] sum;
		d = $realtobits(r);
		e = int'(d[62:52]);
		if (e == 0) return {d[63], 31'b0};
		if (e == 2047) return {d[63], 8'hFF, 23'h400000};
		eb = e - 1023 + 127;
		m = {11'b0, 1'b1, d[51:0]};
		sh = 29;
		if (eb < 1) begin
			sh = 29 + 1 - eb;
			eb = 0;
		end
		if (sh > 60) return {d[63], 31'b0};
		kept = m >> sh;
		g = (m >> (sh - 1)) & 1;
		stk = (m & ((64'd1 << (sh - 1)) - 1)) != 0;
		up = g & (stk | kept[0]);
		sum = (34'((eb >= 1) ? eb - 1 : 0) << 23) + 34'(kept) + 34'(up);
		if (sum >= (34'd255 << 23)) return {d[63], 8'hFF, 23'b0};
		return {d[63], sum[30:0]};
	endfunction

	function automatic bit [31:0] fmul(bit [31:0] a, bit [31:0] b);
		return real_to_single(single_to_real(a) * single_to_real(b));
	endfunction

	function automatic bit [31:0] fadd(bit [31:0] a, bit [31:0] b);
		return real_to_single(single_to_real(a) + single_to_real(b));
	endfunction

	// moderate normal values (or zero): keeps multiplies away from NaN, inf and subnormals
	function automatic bit is_tame(bit [31:0] b);
		return b[30:0] == 0 || (b[30:23] >= 8'd107 && b[30:23] <= 8'd147);
	endfunction

	// matrix stack predictor plus queue of expected output beats
	class matrix_result_board;
		bit [31:0] mats[MV_LEVELS + PJ_LEVELS][16];
		bit [31:0] operand_buf[16];
		bit [15:0] operand_written;
		int level[2];
		bit level0_loaded[2];
		bit immediate;
		result_beat_t pending_beats[$];
		int mismatches;
		int checked;

		function int top_slot(bit sel);
			return sel ? MV_LEVELS + level[1] : level[0];
		endfunction

		function bit top_tame(bit sel);
			int s;
			s = top_slot(sel);
			for (int i = 0; i < 16; i++) if (!is_tame(mats[s][i])) return 0;
			return 1;
		endfunction

		function bit operand_tame();
			foreach (operand_buf[i]) if (!is_tame(operand_buf[i])) return 0;
			return 1;
		endfunction

		function void expect_one(status_t st, bit [3:0] ri, bit [31:0] rv, bit rl);
			result_beat_t r;
			r.st = st;
			r.ri = ri;
			r.rv = rv;
			r.rl = rl;
			pending_beats.push_back(r);
		endfunction

		function void note_command(op_t op, bit sel, bit [3:0] idx, bit [31:0] val, bit last);
			int s, lim;
			bit [31:0] om[16];
			bit [31:0] prod[16];
			bit tr;
			if (op >= OP_LOAD && op <= OP_MUL_T) begin
				operand_buf[idx] = val;
				operand_written[idx] = 1'b1;
				if (!last) return;
			end
			if (immediate) begin
				expect_one(STAT_INVALID, 0, 0, 1);
				return;
			end
			s = top_slot(sel);
			lim = sel ? PJ_LEVELS : MV_LEVELS;
			tr = (op == OP_LOAD_T || op == OP_MUL_T);
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					om[r + 4 * c] = operand_buf[tr ? c + 4 * r : r + 4 * c];
			case (op)
				OP_IDENT: begin
					for (int i = 0; i < 16; i++) mats[s][i] = (i % 5 == 0) ? FP_ONE : 32'h0;
					level0_loaded[sel] = 1;
				end
				OP_PUSH: begin
					if (level[sel] >= lim - 1) begin
						expect_one(STAT_OVERFLOW, 0, 0, 1);
						return;
					end
					mats[s + 1] = mats[s];
					level[sel]++;
				end
				OP_POP: begin
					if (level[sel] == 0) begin
						expect_one(STAT_UNDERFLOW, 0, 0, 1);
						return;
					end
					level[sel]--;
				end
				OP_LOAD, OP_LOAD_T: begin
					mats[s] = om;
					level0_loaded[sel] = 1;
				end
				OP_MUL, OP_MUL_T: begin
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++)
							prod[r + 4 * c] = fadd(fadd(fadd(
								fmul(mats[s][r], om[4 * c]),
								fmul(mats[s][r + 4], om[1 + 4 * c])),
								fmul(mats[s][r + 8], om[2 + 4 * c])),
								fmul(mats[s][r + 12], om[3 + 4 * c]));
					mats[s] = prod;
				end
				default: begin
					for (int i = 0; i < 16; i++)
						expect_one(STAT_OK, 4'(i), mats[s][i], i == 15);
					return;
				end
			endcase
			expect_one(STAT_OK, 0, 0, 1);
		endfunction

		function void check_beat(bit [1:0] st, bit [3:0] ri, bit [31:0] rv, bit rl);
			result_beat_t e;
			checked++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d index %0d value %h last %0d",
						st, ri, rv, rl);
				return;
			end
			e = pending_beats.pop_front();
			if (st != e.st || ri != e.ri || rv != e.rv || rl != e.rl) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected st %0d idx %0d val %h last %0d, got st %0d idx %0d val %h last %0d",
						e.st, e.ri, e.rv, e.rl, st, ri, rv, rl);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [S_DW-1:0] s_tdata;
	logic [S_UW-1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [M_DW-1:0] m_tdata;
	logic [M_UW-1:0] m_tuser;
	logic m_tlast;

	matrix_result_board board;
	int beats_sent;
	int cmd_count[8];
	int idle_cycles;
	int hold_cnt;
	int stall_mode;
	int burst_left;
	bit gaps_on;

	matrix_stack_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: stall pattern changes at random; a long hold-off when requested
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// output monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_beat(m_tuser[1:0], m_tdata[3:0], m_tdata[35:4], m_tlast);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// one input beat, held until accepted; bursts with random gaps between them
	task automatic send_beat(op_t op, bit sel, bit [3:0] idx, bit [31:0] val, bit last);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, val, idx};
		s_tuser  <= {sel, op};
		s_tlast  <= last;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		board.note_command(op, sel, idx, val, last);
		beats_sent++;
		burst_left--;
		if (gaps_on && burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	function automatic bit [31:0] tame_value();
		if ($urandom_range(0, 15) == 0) return {1'($urandom_range(0, 1)), 31'b0};
		return {1'($urandom_range(0, 1)), 8'($urandom_range(120, 134)), 23'($urandom)};
	endfunction

	// stream shape: 0 full 16 beats, 1 a few beats then last, 2 a few beats without last
	task automatic run_cmd(op_t op, bit sel, int shape, bit tame);
		int perm[16];
		int n;
		bit [31:0] v;
		cmd_count[op]++;
		if (op >= OP_LOAD && op <= OP_MUL_T) begin
			foreach (perm[i]) perm[i] = i;
			perm.shuffle();
			n = (shape == 0) ? 16 : $urandom_range(1, 15);
			for (int i = 0; i < n; i++) begin
				v = tame ? tame_value() : $urandom;
				send_beat(op, sel, 4'(perm[i]), v, (shape != 2) && (i == n - 1));
			end
		end else begin
			send_beat(op, sel, 4'($urandom), $urandom, 1'($urandom));
		end
	endtask

	task automatic load_values(op_t op, bit sel, bit [31:0] vals[16]);
		cmd_count[op]++;
		for (int i = 0; i < 16; i++) send_beat(op, sel, 4'(i), vals[i], i == 15);
	endtask

	// mode register is written only with nothing in flight
	task automatic set_immediate(bit v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending_beats.size() != 0) @(posedge clk);
		repeat (50) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		board.immediate = v;
	endtask

	task automatic random_phase(int n_beats);
		op_t op;
		bit sel;
		int shape, r, stop_at;
		bit tame, hold_done;
		stop_at = beats_sent + n_beats;
		hold_done = 0;
		while (beats_sent < stop_at) begin
			op = op_t'($urandom_range(0, 7));
			sel = $urandom_range(0, 1);
			tame = $urandom_range(0, 1);
			if (!board.immediate) begin
				if ((op == OP_PUSH || op == OP_MUL || op == OP_MUL_T || op == OP_READ) &&
						!board.level0_loaded[sel])
					op = OP_IDENT;
				if ((op == OP_MUL || op == OP_MUL_T) && !board.top_tame(sel)) begin
					op = OP_LOAD;
					tame = 1;
				end
				if (op == OP_MUL || op == OP_MUL_T) tame = 1;
			end
			r = $urandom_range(0, 9);
			shape = 0;
			if (board.operand_written == 16'hFFFF &&
					(op == OP_LOAD || op == OP_LOAD_T || board.operand_tame() || board.immediate))
				shape = (r < 2) ? 1 : (r == 2) ? 2 : 0;
			if (!hold_done && beats_sent > stop_at - n_beats / 2 && !board.immediate &&
					board.level0_loaded[sel]) begin
				hold_cnt = HOLD_LEN;
				hold_done = 1;
				repeat (4) run_cmd(OP_READ, sel, 0, 0);
			end
			run_cmd(op, sel, shape, tame);
		end
	endtask

	initial begin
		bit [31:0] vals[16];
		board = new();
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		hold_cnt = 0;
		stall_mode = 0;
		burst_left = 4;
		gaps_on = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: underflow at level zero, extreme operand patterns, every operation
		set_immediate(1'b0);
		run_cmd(OP_POP, 0, 0, 0);
		run_cmd(OP_IDENT, 0, 0, 0);
		run_cmd(OP_IDENT, 1, 0, 0);
		run_cmd(OP_READ, 0, 0, 0);
		foreach (vals[i]) vals[i] = (i % 4 == 0) ? 32'hFFFF_FFFF : (i % 4 == 1) ? 32'h0 :
			(i % 4 == 2) ? 32'h8000_0000 : 32'h7F80_0000;
		load_values(OP_LOAD, 0, vals);
		run_cmd(OP_READ, 0, 0, 0);
		foreach (vals[i]) vals[i] = 32'h3F80_0000 + 32'(i << 20);
		load_values(OP_LOAD_T, 1, vals);
		run_cmd(OP_READ, 1, 0, 0);
		run_cmd(OP_LOAD, 0, 0, 1);
		run_cmd(OP_MUL, 0, 0, 1);
		run_cmd(OP_MUL_T, 1, 0, 1);
		run_cmd(OP_READ, 0, 0, 0);
		run_cmd(OP_READ, 1, 0, 0);
		// projection stack: fill to overflow, then empty to underflow
		repeat (PJ_LEVELS) run_cmd(OP_PUSH, 1, 0, 0);
		run_cmd(OP_READ, 1, 0, 0);
		repeat (PJ_LEVELS) run_cmd(OP_POP, 1, 0, 0);
		// modelview depth sweep up to overflow and back down to level one
		repeat (MV_LEVELS) run_cmd(OP_PUSH, 0, 0, 0);
		repeat (MV_LEVELS - 2) run_cmd(OP_POP, 0, 0, 0);

		// random phases, one with the mode register set and one without gaps
		random_phase(80);
		set_immediate(1'b1);
		random_phase(20);
		run_cmd(OP_READ, 0, 0, 0);
		set_immediate(1'b0);
		gaps_on = 0;
		random_phase(40);
		gaps_on = 1;
		random_phase(80);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending_beats.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d input beats: ident %0d push %0d pop %0d load %0d/%0d mul %0d/%0d read %0d",
			beats_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
			cmd_count[5], cmd_count[6], cmd_count[7]);
		$display("checked %0d result beats, %0d mismatches, %0d still expected",
			board.checked, board.mismatches, board.pending_beats.size());
		if (board.mismatches == 0 && board.pending_beats.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
